// File: design/timeout_slot_table_assert.svh
// ---------------------------------------------------------------------------
// Timeout slot table assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TIMEOUT_SLOT_TABLE_ASSERT_SVH
`define TIMEOUT_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timeout_slot_table: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timeout_slot_table: next-cycle check failed");

`endif

// File: design/tst_pkg.sv
// ---------------------------------------------------------------------------
// Timeout slot table package
// Shared types, sizes and codes for the timeout slot table.
// ---------------------------------------------------------------------------
package tst_pkg;

  // Table size and derived widths.
  localparam int unsigned SLOTS       = 32;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1);
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned FOUND_W     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SLOT_NUM_W  = 5;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_CANCEL   = 2'd2
  } kind_e;

  // Result event codes.
  localparam logic EV_REGISTER = 1'b0;
  localparam logic EV_EXPIRE   = 1'b1;

  // Request payload.
  typedef struct packed {
    logic [1:0]            kind;
    logic [31:0]           delay_ticks;
    logic [SLOT_NUM_W-1:0] cancel_slot;
    logic [31:0]           owner_tag;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic                  event_res;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  granted;
    logic [31:0]           expired_tag;
    logic                  last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic flush;
    logic alloc_step;
    logic cancel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic alloc_hit;
    logic alloc_full;
  } status_t;

endpackage

// File: design/tst_datapath.sv
// ---------------------------------------------------------------------------
// Timeout slot table datapath
// Tick counter, slot active bits, expiry and tag memories, scan pipeline and
// result register.
// ---------------------------------------------------------------------------
module tst_datapath import tst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  req_t    req_i,
  output status_t status_o,
  output logic    res_valid_o,
  output res_t    res_o
);

  // Expiry and tag memories, one entry per slot.
  logic [31:0] exp_mem [SLOTS];
  logic [31:0] tag_mem [SLOTS];

  logic [31:0]        tick_count_q;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [CNT_W-1:0]   rd_idx_q;
  logic               cmp_v_q;
  logic [SLOT_W-1:0]  cmp_idx_q;
  logic [FOUND_W-1:0] found_cnt_q;
  logic               pend_v_q;
  logic [SLOT_W-1:0]  pend_slot_q;
  logic [31:0]        pend_tag_q;
  logic [31:0]        exp_rd_q;
  logic [31:0]        tag_rd_q;
  req_t               item_q;
  logic               res_v_q, res_v_d;
  res_t               res_q, res_d;

  logic              in_range;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_en;
  logic              hit;
  logic              alloc_hit;
  logic              mem_we;
  logic              cancel_ok;

  // Scan position decode and slot match.
  assign in_range  = rd_idx_q < CNT_W'(SLOTS);
  assign rd_addr   = rd_idx_q[SLOT_W-1:0];
  assign rd_en     = cmd_i.scan_step && in_range;
  assign hit       = cmd_i.scan_step && cmp_v_q && active_q[cmp_idx_q] &&
                     (tick_count_q >= exp_rd_q) &&
                     (found_cnt_q < FOUND_W'(MAX_RESULTS));
  assign alloc_hit = in_range && !active_q[rd_addr];
  assign mem_we    = cmd_i.alloc_step && alloc_hit;
  assign cancel_ok = 32'(item_q.cancel_slot) < 32'(SLOTS);

  assign status_o.scan_done  = !in_range && !cmp_v_q;
  assign status_o.alloc_hit  = alloc_hit;
  assign status_o.alloc_full = !in_range;

  // Memory write on allocation and registered read during the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      exp_mem[rd_addr] <= tick_count_q + item_q.delay_ticks;
      tag_mem[rd_addr] <= item_q.owner_tag;
    end
    if (rd_en) begin
      exp_rd_q <= exp_mem[rd_addr];
      tag_rd_q <= tag_mem[rd_addr];
    end
  end

  // Next value of the active bits.
  always_comb begin
    active_d = active_q;
    if (hit) begin
      active_d[cmp_idx_q] = 1'b0;
    end
    if (mem_we) begin
      active_d[rd_addr] = 1'b1;
    end
    if (cmd_i.cancel && cancel_ok) begin
      active_d[SLOT_W'(item_q.cancel_slot)] = 1'b0;
    end
  end

  // Result selection; an expiry is held back one find so the final one can
  // carry the last flag.
  always_comb begin
    res_v_d = 1'b0;
    res_d   = res_q;
    if (hit && pend_v_q) begin
      res_v_d           = 1'b1;
      res_d.event_res   = EV_EXPIRE;
      res_d.slot_number = SLOT_NUM_W'(pend_slot_q);
      res_d.granted     = 1'b0;
      res_d.expired_tag = pend_tag_q;
      res_d.last        = 1'b0;
    end else if (cmd_i.flush && pend_v_q) begin
      res_v_d           = 1'b1;
      res_d.event_res   = EV_EXPIRE;
      res_d.slot_number = SLOT_NUM_W'(pend_slot_q);
      res_d.granted     = 1'b0;
      res_d.expired_tag = pend_tag_q;
      res_d.last        = 1'b1;
    end else if (cmd_i.alloc_step && (alloc_hit || !in_range)) begin
      res_v_d           = 1'b1;
      res_d.event_res   = EV_REGISTER;
      res_d.slot_number = alloc_hit ? SLOT_NUM_W'(rd_addr) : '0;
      res_d.granted     = alloc_hit;
      res_d.expired_tag = '0;
      res_d.last        = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      active_q     <= '0;
      rd_idx_q     <= '0;
      cmp_v_q      <= 1'b0;
      found_cnt_q  <= '0;
      pend_v_q     <= 1'b0;
      res_v_q      <= 1'b0;
    end else begin
      active_q <= active_d;
      res_v_q  <= res_v_d;
      if (cmd_i.load) begin
        rd_idx_q    <= '0;
        cmp_v_q     <= 1'b0;
        found_cnt_q <= '0;
        pend_v_q    <= 1'b0;
        if (req_i.kind == KIND_TICK) begin
          tick_count_q <= tick_count_q + 32'd1;
        end
      end else begin
        if (cmd_i.scan_step) begin
          cmp_v_q <= rd_en;
          if (in_range) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
        end
        if (cmd_i.alloc_step && in_range && !alloc_hit) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (hit) begin
          pend_v_q    <= 1'b1;
          found_cnt_q <= found_cnt_q + FOUND_W'(1);
        end else if (cmd_i.flush) begin
          pend_v_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load) begin
      item_q <= req_i;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_addr;
    end
    if (hit) begin
      pend_slot_q <= cmp_idx_q;
      pend_tag_q  <= tag_rd_q;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// File: design/tst_ctrl.sv
// ---------------------------------------------------------------------------
// Timeout slot table controller
// One-hot state machine that sequences tick scans, allocations and cancels.
// ---------------------------------------------------------------------------
module tst_ctrl import tst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_TICK   = 4'b0010,
    ST_ALLOC  = 4'b0100,
    ST_CANCEL = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = state_q != ST_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (kind_i)
            KIND_TICK:     state_d = ST_TICK;
            KIND_REGISTER: state_d = ST_ALLOC;
            KIND_CANCEL:   state_d = ST_CANCEL;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (status_i.scan_done) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (status_i.alloc_hit || status_i.alloc_full) begin
          state_d = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        cmd_o.cancel = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/timeout_slot_table.sv
// Tick: a memory scan of one slot a cycle over every slot.
// Register: a search for the lowest free slot.
// A new request is taken only while busy_o is low.
// Each result is a one-cycle strobe; an expiry waits for the next find or the scan end.
// Reset clears the tick count, the active bits and all control state at once.
// ---------------------------------------------------------------------------
// Timeout slot table top level
// Tick counter and table of timeout slots with allocation, cancel and expiry.
// ---------------------------------------------------------------------------
`include "timeout_slot_table_assert.svh"

module timeout_slot_table import tst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t    cmd;
  status_t status;

  // Controller.
  tst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (req_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Datapath.
  tst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A tick request keeps the block busy while it scans.
  `TST_ASSERT_NEXT(a_tick_busy, start_i && !busy_o && req_i.kind == KIND_TICK, busy_o)
  // No result can appear in the cycle right after a request is taken.
  `TST_ASSERT_NEXT(a_no_early_res, start_i && !busy_o, !res_valid_o)
  // Register answers are always final and carry no tag.
  `TST_ASSERT_NOW(a_reg_answer, res_valid_o && res_o.event_res == EV_REGISTER,
                  res_o.last && res_o.expired_tag == 32'd0)

endmodule
